>>> design/json_string_unescape_utf8_assert.svh
// Assertion macros for the JSON string decoder.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTHESIS

`define JSU_ASSERT_IMPLIES(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("jsu assertion failed");

`define JSU_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("jsu assertion failed");

`else

`define JSU_ASSERT_IMPLIES(lbl, clk_s, rst_s, pre, post)

`define JSU_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post)

`endif

`endif

>>> design/jsu_pkg.sv
// Types and codes for the JSON string decoder.
package jsu_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_BODY   = 4'b0010,
    MODE_ESCAPE = 4'b0100,
    MODE_HEX    = 4'b1000
  } mode_t;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_NO_QUOTE = 3'd1;
  localparam logic [2:0] CAUSE_CONTROL  = 3'd2;
  localparam logic [2:0] CAUSE_ESCAPE   = 3'd3;
  localparam logic [2:0] CAUSE_HEX      = 3'd4;
  localparam logic [2:0] CAUSE_ENDED    = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] byte_val;
    logic [1:0] kind;
    logic [2:0] cause;
    logic       last;
  } result_t;

endpackage

>>> design/json_string_unescape_utf8.sv
// JSON string literal decoder: one input byte per beat, unescaped UTF-8 bytes out.
// Takes one byte per cycle while s_axis_tready is high; an input beat's first result
// is on the bus in the cycle after it. Each input beat makes zero to three result
// beats, held in a three-entry output buffer that drains one entry per cycle while
// m_axis_tready is high; s_axis_tready is high while that buffer is empty or about
// to send its final entry. A \uXXXX escape that encodes to two or three UTF-8 bytes
// therefore holds off input while they drain; every other byte runs at full rate.
// An error result is single and returns the decoder to waiting for an opening quote.
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [4:0] m_axis_tuser,   // [1:0] kind, [4:2] error_cause
  output logic       m_axis_tlast    // last_of_run
);

  jsu_pkg::mode_t   mode, mode_next;
  logic [1:0]       digits, digits_next;
  logic [11:0]      acc, acc_next;

  jsu_pkg::result_t res [3];
  jsu_pkg::result_t new_res [3];
  logic [1:0]       rem;
  logic [1:0]       new_cnt;

  logic             in_beat;
  logic             out_beat;
  logic [7:0]       c;
  logic [4:0]       hex;
  logic [15:0]      cp;

  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, ch[3:0]};
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      r = {1'b1, ch[3:0] + 4'd9};
    return r;
  endfunction

  function automatic jsu_pkg::result_t mk(input logic [7:0] b, input logic [1:0] k,
                                          input logic [2:0] e);
    jsu_pkg::result_t r;
    r.byte_val = b;
    r.kind     = k;
    r.cause    = e;
    r.last     = 1'b0;
    return r;
  endfunction

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (rem == 2'd0) || (rem == 2'd1 && m_axis_tready);
  assign c             = s_axis_tdata;
  assign hex           = hex_digit(c);
  assign cp            = {acc, hex[3:0]};

  always_comb begin
    mode_next   = mode;
    digits_next = digits;
    acc_next    = acc;
    new_cnt     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      new_res[i] = mk(8'h00, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
    end

    if (s_axis_tuser) begin
      new_res[0] = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::CAUSE_ENDED);
      new_cnt    = 2'd1;
      mode_next  = jsu_pkg::MODE_IDLE;
    end else begin
      unique case (mode)
        jsu_pkg::MODE_IDLE: begin
          if (c == jsu_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            new_cnt = 2'd0;
          end else if (c == jsu_pkg::CH_QUOTE) begin
            mode_next = jsu_pkg::MODE_BODY;
          end else begin
            new_res[0] = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::CAUSE_NO_QUOTE);
            new_cnt    = 2'd1;
          end
        end
        jsu_pkg::MODE_BODY: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            new_res[0] = mk(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::CAUSE_NONE);
            new_cnt    = 2'd1;
            mode_next  = jsu_pkg::MODE_IDLE;
          end else if (c < jsu_pkg::CH_SPACE) begin
            new_res[0] = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::CAUSE_CONTROL);
            new_cnt    = 2'd1;
            mode_next  = jsu_pkg::MODE_IDLE;
          end else if (c == jsu_pkg::CH_BSLASH) begin
            mode_next = jsu_pkg::MODE_ESCAPE;
          end else begin
            new_res[0] = mk(c, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            new_cnt    = 2'd1;
          end
        end
        jsu_pkg::MODE_ESCAPE: begin
          mode_next = jsu_pkg::MODE_BODY;
          new_cnt   = 2'd1;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              new_res[0] = mk(c, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            8'h62: new_res[0] = mk(8'h08, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            8'h66: new_res[0] = mk(8'h0C, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            8'h6E: new_res[0] = mk(8'h0A, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            8'h72: new_res[0] = mk(8'h0D, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            8'h74: new_res[0] = mk(8'h09, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
            8'h75: begin
              mode_next   = jsu_pkg::MODE_HEX;
              digits_next = 2'd0;
              acc_next    = 12'd0;
              new_cnt     = 2'd0;
            end
            default: begin
              new_res[0] = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::CAUSE_ESCAPE);
              mode_next  = jsu_pkg::MODE_IDLE;
            end
          endcase
        end
        jsu_pkg::MODE_HEX: begin
          if (!hex[4]) begin
            new_res[0] = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::CAUSE_HEX);
            new_cnt    = 2'd1;
            mode_next  = jsu_pkg::MODE_IDLE;
          end else if (digits != 2'd3) begin
            acc_next    = {acc[7:0], hex[3:0]};
            digits_next = digits + 2'd1;
          end else begin
            mode_next = jsu_pkg::MODE_BODY;
            if (cp[15:7] == 9'd0) begin
              new_res[0] = mk({1'b0, cp[6:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
              new_cnt    = 2'd1;
            end else if (cp[15:11] == 5'd0) begin
              new_res[0] = mk({3'b110, cp[10:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
              new_res[1] = mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
              new_cnt    = 2'd2;
            end else begin
              new_res[0] = mk({4'b1110, cp[15:12]}, jsu_pkg::KIND_BYTE,
                              jsu_pkg::CAUSE_NONE);
              new_res[1] = mk({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
              new_res[2] = mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::CAUSE_NONE);
              new_cnt    = 2'd3;
            end
          end
        end
        default: mode_next = jsu_pkg::MODE_IDLE;
      endcase
    end

    // any exit to idle or body leaves the \u scratch cleared
    if (mode_next != jsu_pkg::MODE_HEX) begin
      digits_next = 2'd0;
      acc_next    = 12'd0;
    end

    case (new_cnt)
      2'd1:    new_res[0].last = 1'b1;
      2'd2:    new_res[1].last = 1'b1;
      2'd3:    new_res[2].last = 1'b1;
      default: new_res[0].last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= jsu_pkg::MODE_IDLE;
      digits <= 2'd0;
      acc    <= 12'd0;
    end else if (in_beat) begin
      mode   <= mode_next;
      digits <= digits_next;
      acc    <= acc_next;
    end
  end

  // output buffer: entry 0 is on the bus, entries shift down per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (in_beat) begin
      rem <= new_cnt;
    end else if (out_beat) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res[0] <= new_res[0];
      res[1] <= new_res[1];
      res[2] <= new_res[2];
    end else if (out_beat) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  assign m_axis_tvalid = (rem != 2'd0);
  assign m_axis_tdata  = res[0].byte_val;
  assign m_axis_tuser  = {res[0].cause, res[0].kind};
  assign m_axis_tlast  = res[0].last;

  `JSU_ASSERT_IMPLIES(a_err_single, clk, rst, m_axis_tvalid && m_axis_tuser[1:0] == jsu_pkg::KIND_ERROR, m_axis_tlast && rem == 2'd1)
  `JSU_ASSERT_IMPLIES(a_ctrl_no_data, clk, rst, m_axis_tvalid && m_axis_tuser[1:0] != jsu_pkg::KIND_BYTE, m_axis_tdata == 8'h00)
  `JSU_ASSERT_IMPLIES(a_last_at_end, clk, rst, m_axis_tvalid, m_axis_tlast == (rem == 2'd1))
  `JSU_ASSERT_NEXT(a_end_to_idle, clk, rst, in_beat && s_axis_tuser, mode == jsu_pkg::MODE_IDLE && acc == 12'd0)

endmodule
